[design/rhf_pkg.sv]
// Shared types, constants and byte-class helpers for the request header framer.
// No dependencies; imported by rhf_digit_acc and request_header_framer_unit.
`default_nettype none

package rhf_pkg;

  // Byte roles on the result channel
  typedef enum logic [2:0] {
    ROLE_DELIM    = 3'd0,
    ROLE_COMMAND  = 3'd1,
    ROLE_RESOURCE = 3'd2,
    ROLE_NAME     = 3'd3,
    ROLE_VALUE    = 3'd4,
    ROLE_BODY     = 3'd5
  } role_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Length of the "Content-length" key
  localparam logic [3:0] KEY_LEN = 4'd14;

  function automatic logic [7:0] key_byte(input logic [3:0] idx);
    logic [7:0] k;
    case (idx)
      4'd0:    k = "C";
      4'd1:    k = "o";
      4'd2:    k = "n";
      4'd3:    k = "t";
      4'd4:    k = "e";
      4'd5:    k = "n";
      4'd6:    k = "t";
      4'd7:    k = "-";
      4'd8:    k = "l";
      4'd9:    k = "e";
      4'd10:   k = "n";
      4'd11:   k = "g";
      4'd12:   k = "t";
      4'd13:   k = "h";
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  function automatic logic is_print(input logic [7:0] b);
    return (b >= 8'h20) && (b <= 8'h7E);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage

`default_nettype wire

[design/request_header_framer_unit.sv]
// Request header framer top level: byte-serial request parser and tagger.
// Depends on rhf_pkg and rhf_digit_acc.
//
// Usage:
//   The in_ channel carries one raw stream byte per beat (valid/ready). Each
//   accepted beat yields exactly one result beat on the out_ channel: the byte
//   itself, its role (delimiter, command, resource, header name, header value,
//   body), header commit / Content-length / end-of-headers flags, the content
//   length in effect, a request-done marker and the sticky malformed flag.
//   The result is registered and on out_ from the edge accepting its byte.
//   Throughput is one byte per cycle unless the receiver stalls; the parser
//   state and the result register both update in the accepting cycle, and the
//   limit is the single parser step (name match plus saturating times-ten add).
//   When the receiver stalls, the result register holds its beat and in_ready
//   drops, so no byte is taken until the pending result is consumed; a new
//   byte is taken in the same cycle the old result leaves.
//   Reset (rst_n low, synchronous) returns the parser to the command line,
//   clears the length registers and the malformed state, and empties the
//   result register. Malformed is sticky: after the first bad byte every beat
//   reports role delimiter, no flags and malformed set, until reset.
//   LENGTH_BITS (16..32) sets the saturation width of the length value.
`default_nettype none

module request_header_framer_unit #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_out_byte,
  output logic [2:0]       out_byte_role,
  output logic             out_header_committed,
  output logic             out_header_is_length,
  output logic             out_headers_finished,
  output logic [31:0]      out_body_length,
  output logic             out_request_done,
  output logic             out_malformed
);
  import rhf_pkg::*;

  typedef enum logic [3:0] {
    ST_CMD       = 4'd0,
    ST_RES       = 4'd1,
    ST_CMD_LF    = 4'd2,
    ST_SEEK_NAME = 4'd3,
    ST_NAME      = 4'd4,
    ST_SEEK_VAL  = 4'd5,
    ST_VAL       = 4'd6,
    ST_VAL_LF    = 4'd7,
    ST_END_LF    = 4'd8,
    ST_BODY      = 4'd9,
    ST_BAD       = 4'd10
  } phase_t;

  // parser state
  phase_t                 phase_r, phase_nxt;
  logic [3:0]             idx_r, idx_nxt;
  logic                   still_r, still_nxt;
  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;
  logic                   stopped_r, stopped_nxt;
  logic [LENGTH_BITS-1:0] pend_r, pend_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;

  // result register
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  role_t       role_r;
  logic        committed_r, is_len_r, finished_r, done_r, malformed_r;
  logic [31:0] blen_r;

  // per-byte decode
  role_t                  role;
  logic                   committed, is_len, finished, done, bad, clear_after;
  logic                   hdr_phase, name_is_len;
  logic [3:0]             idx_base, idx_fed;
  logic                   still_base, still_fed;
  logic [LENGTH_BITS-1:0] acc_base, acc_fed, rem_dec;
  logic                   stopped_base, stopped_fed;
  logic [LENGTH_BITS-1:0] blen;
  logic [7:0]             b;
  logic                   accept;

  assign b         = in_data_byte;
  // take nothing while reset is held
  assign in_ready  = rst_n && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign hdr_phase = phase_r inside {ST_SEEK_NAME, ST_NAME, ST_SEEK_VAL, ST_VAL, ST_VAL_LF};
  assign name_is_len = still_r && (idx_r == KEY_LEN);

  // A fresh name or value starts from the reset match / accumulator state
  assign idx_base     = (phase_r == ST_SEEK_NAME) ? 4'd0 : idx_r;
  assign still_base   = (phase_r == ST_SEEK_NAME) ? 1'b1 : still_r;
  assign acc_base     = (phase_r == ST_SEEK_VAL) ? '0 : acc_r;
  assign stopped_base = (phase_r == ST_SEEK_VAL) ? 1'b0 : stopped_r;

  // Name match against the Content-length key
  always_comb begin
    idx_fed   = idx_base;
    still_fed = still_base;
    if (idx_base < KEY_LEN) begin
      if (key_byte(idx_base) != b) begin
        still_fed = 1'b0;
      end
      idx_fed = idx_base + 4'd1;
    end else begin
      still_fed = 1'b0;
    end
  end

  rhf_digit_acc #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_digit_acc (
    .acc_i     (acc_base),
    .stopped_i (stopped_base),
    .byte_i    (b),
    .acc_o     (acc_fed),
    .stopped_o (stopped_fed)
  );

  assign rem_dec = (rem_r != '0) ? (rem_r - LENGTH_BITS'(1)) : rem_r;

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    still_nxt   = still_r;
    acc_nxt     = acc_r;
    stopped_nxt = stopped_r;
    pend_nxt    = pend_r;
    rem_nxt     = rem_r;
    role        = ROLE_DELIM;
    committed   = 1'b0;
    is_len      = 1'b0;
    finished    = 1'b0;
    done        = 1'b0;
    clear_after = 1'b0;
    // header section accepts only printable bytes and whitespace
    bad         = hdr_phase && !is_print(b) && !is_space(b);

    if (!bad) begin
      case (phase_r)
        ST_CMD, ST_RES: begin
          if (b == CH_CR) begin
            phase_nxt = ST_CMD_LF;
          end else if (b == CH_SPACE) begin
            phase_nxt = ST_RES;
          end else if (!is_print(b)) begin
            bad = 1'b1;
          end else begin
            role = (phase_r == ST_CMD) ? ROLE_COMMAND : ROLE_RESOURCE;
          end
        end
        ST_CMD_LF: begin
          if (b == CH_LF) begin
            pend_nxt  = '0;
            phase_nxt = ST_SEEK_NAME;
          end else begin
            bad = 1'b1;
          end
        end
        ST_SEEK_NAME: begin
          if (b == CH_CR) begin
            phase_nxt = ST_END_LF;
          end else if (!is_space(b)) begin
            idx_nxt   = idx_fed;
            still_nxt = still_fed;
            role      = ROLE_NAME;
            phase_nxt = ST_NAME;
          end
        end
        ST_NAME: begin
          if (b == CH_COLON) begin
            phase_nxt = ST_SEEK_VAL;
          end else begin
            idx_nxt   = idx_fed;
            still_nxt = still_fed;
            role      = ROLE_NAME;
          end
        end
        ST_SEEK_VAL: begin
          if (!is_space(b)) begin
            role      = ROLE_VALUE;
            phase_nxt = ST_VAL;
            acc_nxt   = '0;
            if (b == CH_MINUS) begin
              // negative length is rejected; other headers just stop digits
              if (name_is_len) begin
                bad = 1'b1;
              end else begin
                stopped_nxt = 1'b1;
              end
            end else if (b == CH_PLUS) begin
              stopped_nxt = 1'b0;
            end else begin
              acc_nxt     = acc_fed;
              stopped_nxt = stopped_fed;
            end
          end
        end
        ST_VAL: begin
          if (b == CH_CR) begin
            phase_nxt = ST_VAL_LF;
          end else begin
            acc_nxt     = acc_fed;
            stopped_nxt = stopped_fed;
            role        = ROLE_VALUE;
          end
        end
        ST_VAL_LF: begin
          if (b == CH_LF) begin
            committed = 1'b1;
            if (name_is_len) begin
              is_len   = 1'b1;
              pend_nxt = acc_r;
            end
            phase_nxt = ST_SEEK_NAME;
          end else begin
            bad = 1'b1;
          end
        end
        ST_END_LF: begin
          if (b == CH_LF) begin
            finished = 1'b1;
            if (pend_r == '0) begin
              done      = 1'b1;
              phase_nxt = ST_CMD;
            end else begin
              rem_nxt   = pend_r;
              phase_nxt = ST_BODY;
            end
          end else begin
            bad = 1'b1;
          end
        end
        ST_BODY: begin
          role    = ROLE_BODY;
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            done        = 1'b1;
            clear_after = 1'b1;
            phase_nxt   = ST_CMD;
          end
        end
        default: begin
          bad = 1'b1;
        end
      endcase
    end

    if (bad) begin
      // drop all tags and park in the malformed state
      phase_nxt = ST_BAD;
      role      = ROLE_DELIM;
      committed = 1'b0;
      is_len    = 1'b0;
      finished  = 1'b0;
      done      = 1'b0;
    end

    // length reported for this beat is the one before the end-of-request clear
    blen = pend_nxt;
    if (clear_after) begin
      pend_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ST_CMD;
      idx_r       <= 4'd0;
      still_r     <= 1'b1;
      acc_r       <= '0;
      stopped_r   <= 1'b0;
      pend_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        // advance the parser and load the result register together
        phase_r     <= phase_nxt;
        idx_r       <= idx_nxt;
        still_r     <= still_nxt;
        acc_r       <= acc_nxt;
        stopped_r   <= stopped_nxt;
        pend_r      <= pend_nxt;
        rem_r       <= rem_nxt;
        out_valid_r <= 1'b1;
        out_byte_r  <= b;
        role_r      <= role;
        committed_r <= committed;
        is_len_r    <= is_len;
        finished_r  <= finished;
        done_r      <= done;
        blen_r      <= 32'(blen);
        malformed_r <= (phase_nxt == ST_BAD);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_out_byte         = out_byte_r;
  assign out_byte_role        = role_r;
  assign out_header_committed = committed_r;
  assign out_header_is_length = is_len_r;
  assign out_headers_finished = finished_r;
  assign out_body_length      = blen_r;
  assign out_request_done     = done_r;
  assign out_malformed        = malformed_r;

endmodule

`default_nettype wire

[design/rhf_digit_acc.sv]
// Saturating decimal digit accumulator (acc * 10 + digit), stops at first non-digit.
// Depends on rhf_pkg.
`default_nettype none

module rhf_digit_acc #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic [LENGTH_BITS-1:0] acc_i,
  input  wire logic                   stopped_i,
  input  wire logic [7:0]             byte_i,
  output logic      [LENGTH_BITS-1:0] acc_o,
  output logic                        stopped_o
);
  import rhf_pkg::*;

  localparam int unsigned WIDE = LENGTH_BITS + 4;

  logic [WIDE-1:0] wide_sum;
  logic [3:0]      digit;

  assign digit    = 4'(byte_i - CH_ZERO);
  // times ten as times eight plus times two
  assign wide_sum = WIDE'({acc_i, 3'b000}) + WIDE'({acc_i, 1'b0}) + WIDE'(digit);

  always_comb begin
    acc_o     = acc_i;
    stopped_o = stopped_i;
    if (!stopped_i && is_digit(byte_i)) begin
      if (wide_sum[WIDE-1:LENGTH_BITS] != 4'd0) begin
        acc_o = '1;
      end else begin
        acc_o = wide_sum[LENGTH_BITS-1:0];
      end
    end else begin
      stopped_o = 1'b1;
    end
  end

endmodule

`default_nettype wire
